@@ design/folhpf_pkg.sv @@
// package for the first-order low/high-pass filter
// holds default widths, config register indexes and reset values, and the
// command/status structs shared by the controller and the datapath
`timescale 1ns / 1ps
`default_nettype none

package folhpf_pkg;

  localparam int SAMPLE_WIDTH    = 32;
  localparam int ALPHA_FRAC_BITS = 16;
  localparam int TIME_WIDTH      = 32;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int RC_WIDTH   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_PASS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_TIMESTAMPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RC_TICKS       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_DT_TICKS = 2'd3;

  localparam logic [RC_WIDTH-1:0]   RC_TICKS_RESET     = 32'd1592;
  localparam logic [CFG_DATA_W-1:0] FIXED_DT_RESET     = 32'd1000;

  typedef struct packed {
    logic capture;
    logic prep;
    logic div_step;
    logic mul;
    logic fin;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic init;
  } sts_t;

endpackage

`default_nettype wire

@@ design/folhpf_ctrl.sv @@
// controller for the first-order low/high-pass filter
// sequences capture, dt/divider setup, alpha division, multiply, rounding
// and result hand-off; uses folhpf_pkg command and status structs
`timescale 1ns / 1ps
`default_nettype none

module folhpf_ctrl #(
  parameter int ALPHA_FRAC_BITS = folhpf_pkg::ALPHA_FRAC_BITS
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire                out_ready,
  input  wire folhpf_pkg::sts_t sts,
  output folhpf_pkg::cmd_t   cmd
);

  localparam int CNT_W = $clog2(ALPHA_FRAC_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_MUL,
    S_FIN,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state_r == S_IDLE) && in_valid;
    cmd.prep     = (state_r == S_PREP);
    cmd.div_step = (state_r == S_DIV);
    cmd.mul      = (state_r == S_MUL);
    cmd.fin      = (state_r == S_FIN);
    cmd.commit   = (state_r == S_DONE) && slot_free;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (sts.init) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIV;
          cnt_nxt   = CNT_W'(ALPHA_FRAC_BITS - 1);
        end
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_MUL: state_nxt = S_FIN;
      S_FIN: state_nxt = S_DONE;
      S_DONE: begin
        if (slot_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/folhpf_dp.sv @@
// datapath for the first-order low/high-pass filter
// config registers, filter state, bit-serial alpha divider, multiplier,
// rounding and saturation, output payload; driven by folhpf_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module folhpf_dp #(
  parameter int SAMPLE_WIDTH    = folhpf_pkg::SAMPLE_WIDTH,
  parameter int ALPHA_FRAC_BITS = folhpf_pkg::ALPHA_FRAC_BITS,
  parameter int TIME_WIDTH      = folhpf_pkg::TIME_WIDTH
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    cfg_wr_en,
  input  wire  [folhpf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [folhpf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire  signed [SAMPLE_WIDTH-1:0]         in_sample,
  input  wire  [TIME_WIDTH-1:0]                  in_timestamp,
  input  wire                                    in_restart,
  output logic signed [SAMPLE_WIDTH-1:0]         out_filtered,
  output logic                                   out_initialized,
  output logic                                   out_time_stalled,
  input  wire folhpf_pkg::cmd_t                  cmd,
  output folhpf_pkg::sts_t                       sts
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int F      = ALPHA_FRAC_BITS;
  localparam int TW     = TIME_WIDTH;
  localparam int RCW    = folhpf_pkg::RC_WIDTH;
  localparam int DEN_W  = ((TW > RCW) ? TW : RCW) + 1;
  localparam int A_W    = F + 1;
  localparam int D_W    = SW + 2;
  localparam int PROD_W = A_W + 1 + D_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SH_W   = ACC_W - F;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (F - 1);
  localparam logic signed [SH_W-1:0]  YMAX = {{(SH_W - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [SH_W-1:0]  YMIN = ~YMAX;

  // configuration
  logic                             high_pass_r;
  logic                             use_ts_r;
  logic [RCW-1:0]                   rc_r;
  logic [folhpf_pkg::CFG_DATA_W-1:0] fixed_dt_r;

  // filter state
  logic                      primed_r;
  logic signed [SW-1:0]      last_out_r;
  logic signed [SW-1:0]      last_in_r;
  logic [TW-1:0]             last_time_r;
  logic [TW-1:0]             last_dt_r;

  // current transaction
  logic signed [SW-1:0]      x_r;
  logic [TW-1:0]             t_r;
  logic                      restart_r;
  logic                      init_r;
  logic                      stall_r;
  logic signed [SW-1:0]      y_r;

  // divider and arithmetic
  logic [DEN_W-1:0]          den_r;
  logic [DEN_W-1:0]          rem_r;
  logic [A_W-1:0]            alpha_r;
  logic                      zden_r;
  logic signed [PROD_W-1:0]  prod_r;

  logic                      init_c;
  logic                      adv_c;
  logic [TW-1:0]             dt_c;
  logic                      dt_zero_c;
  logic [DEN_W:0]            rem2_c;
  logic                      qbit_c;
  logic [A_W-1:0]            alpha_eff_c;
  logic signed [A_W:0]       alpha_s_c;
  logic signed [D_W-1:0]     d_c;
  logic signed [ACC_W-1:0]   lp_term_c;
  logic signed [ACC_W-1:0]   acc_c;
  logic signed [SH_W-1:0]    sh_c;
  logic signed [SW-1:0]      sat_c;

  assign init_c   = !primed_r || restart_r;
  assign sts.init = init_c;

  always_comb begin
    adv_c = t_r > last_time_r;
    if (use_ts_r) begin
      dt_c = adv_c ? (t_r - last_time_r) : last_dt_r;
    end else begin
      dt_c = TW'(fixed_dt_r);
    end
    dt_zero_c = (dt_c == '0);
  end

  assign rem2_c = {rem_r, 1'b0};
  assign qbit_c = rem2_c >= (DEN_W + 1)'(den_r);

  assign alpha_eff_c = zden_r ? '0 : alpha_r;
  assign alpha_s_c   = $signed({1'b0, alpha_eff_c});

  always_comb begin
    if (high_pass_r) begin
      d_c = D_W'(last_out_r) + D_W'(x_r) - D_W'(last_in_r);
    end else begin
      d_c = D_W'(last_out_r) - D_W'(x_r);
    end
  end

  // low-pass as x + alpha*(y - x), scaled by 2^F
  assign lp_term_c = high_pass_r ? '0 : (ACC_W'(x_r) <<< F);
  assign acc_c     = ACC_W'(prod_r) + lp_term_c + HALF;
  assign sh_c      = $signed(acc_c[ACC_W-1:F]);

  always_comb begin
    if (sh_c > YMAX) begin
      sat_c = YMAX[SW-1:0];
    end else if (sh_c < YMIN) begin
      sat_c = YMIN[SW-1:0];
    end else begin
      sat_c = sh_c[SW-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_pass_r <= 1'b0;
      use_ts_r    <= 1'b0;
      rc_r        <= folhpf_pkg::RC_TICKS_RESET;
      fixed_dt_r  <= folhpf_pkg::FIXED_DT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        folhpf_pkg::REG_HIGH_PASS:      high_pass_r <= cfg_wdata[0];
        folhpf_pkg::REG_USE_TIMESTAMPS: use_ts_r    <= cfg_wdata[0];
        folhpf_pkg::REG_RC_TICKS:       rc_r        <= cfg_wdata[RCW-1:0];
        folhpf_pkg::REG_FIXED_DT_TICKS: fixed_dt_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r    <= 1'b0;
      last_out_r  <= '0;
      last_in_r   <= '0;
      last_time_r <= '0;
      last_dt_r   <= '0;
    end else begin
      if (cmd.prep) begin
        if (init_c) begin
          primed_r    <= 1'b1;
          last_time_r <= use_ts_r ? t_r : '0;
        end else begin
          last_dt_r <= dt_c;
          if (use_ts_r) begin
            last_time_r <= t_r;
            primed_r    <= adv_c;
          end
        end
      end
      if (cmd.commit) begin
        last_out_r <= y_r;
        last_in_r  <= x_r;
      end
    end
  end

  // transaction payload and arithmetic
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r       <= in_sample;
      t_r       <= in_timestamp;
      restart_r <= in_restart;
    end
    if (cmd.prep) begin
      init_r  <= init_c;
      stall_r <= !init_c && use_ts_r && !adv_c;
      if (init_c) begin
        y_r <= x_r;
      end
      den_r   <= DEN_W'(rc_r) + DEN_W'(dt_c);
      rem_r   <= dt_zero_c ? '0 : DEN_W'(rc_r);
      alpha_r <= A_W'(dt_zero_c);
      zden_r  <= dt_zero_c && (rc_r == '0);
    end
    if (cmd.div_step) begin
      rem_r   <= qbit_c ? DEN_W'(rem2_c - (DEN_W + 1)'(den_r)) : DEN_W'(rem2_c);
      alpha_r <= {alpha_r[A_W-2:0], qbit_c};
    end
    if (cmd.mul) begin
      prod_r <= alpha_s_c * d_c;
    end
    if (cmd.fin) begin
      y_r <= sat_c;
    end
    if (cmd.commit) begin
      out_filtered     <= y_r;
      out_initialized  <= init_r;
      out_time_stalled <= stall_r;
    end
  end

endmodule

`default_nettype wire

@@ design/first_order_low_high_pass_filter.sv @@
// first-order low/high-pass filter on signed Q16.16 samples, top level
// an initializing transaction is captured, prepared and handed off; a filtered one
// is captured, prepared, divided for alpha, multiplied and rounded before hand-off
// a new sample is accepted only while idle; a result that waits for out_ready in the
// output register holds the next hand-off back
// reset (synchronous, active low) sets config to defaults and filter state to zero
`timescale 1ns / 1ps
`default_nettype none

module first_order_low_high_pass_filter #(
  parameter int SAMPLE_WIDTH    = folhpf_pkg::SAMPLE_WIDTH,
  parameter int ALPHA_FRAC_BITS = folhpf_pkg::ALPHA_FRAC_BITS,
  parameter int TIME_WIDTH      = folhpf_pkg::TIME_WIDTH
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_wr_en,
  input  wire  [folhpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [folhpf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  signed [SAMPLE_WIDTH-1:0]     in_sample,
  input  wire  [TIME_WIDTH-1:0]              in_timestamp,
  input  wire                                in_restart,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]     out_filtered,
  output logic                               out_initialized,
  output logic                               out_time_stalled
);

  folhpf_pkg::cmd_t cmd;
  folhpf_pkg::sts_t sts;

  folhpf_ctrl #(
    .ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  folhpf_dp #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .ALPHA_FRAC_BITS(ALPHA_FRAC_BITS),
    .TIME_WIDTH     (TIME_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_sample       (in_sample),
    .in_timestamp    (in_timestamp),
    .in_restart      (in_restart),
    .out_filtered    (out_filtered),
    .out_initialized (out_initialized),
    .out_time_stalled(out_time_stalled),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

`default_nettype wire

@@ tb/tb_first_order_low_high_pass_filter.sv @@
`timescale 1ns / 1ps
// testbench for first_order_low_high_pass_filter: directed and random transactions,
// every result checked against a filter model kept inside the bench
// depends on folhpf_pkg and the design top level

module tb_first_order_low_high_pass_filter;

  localparam int SAMPLE_WIDTH    = folhpf_pkg::SAMPLE_WIDTH;
  localparam int ALPHA_FRAC_BITS = folhpf_pkg::ALPHA_FRAC_BITS;
  localparam int TIME_WIDTH      = folhpf_pkg::TIME_WIDTH;
  localparam int CFG_IDX_W       = folhpf_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W      = folhpf_pkg::CFG_DATA_W;
  localparam int RC_WIDTH        = folhpf_pkg::RC_WIDTH;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] filtered;
    logic                           initialized;
    logic                           time_stalled;
  } filt_result_t;

  localparam longint ALPHA_UNITY = longint'(1) << ALPHA_FRAC_BITS;
  localparam longint SAT_HI      = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
  localparam longint SAT_LO      = -SAT_HI - 1;

  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [SAMPLE_WIDTH-1:0] Q_ONE      = 1 << 16;
  localparam logic [31:0]             TICKS_MAX  = '1;

  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          cfg_wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index    = '0;
  logic [CFG_DATA_W-1:0]         cfg_wdata    = '0;
  logic                          in_valid     = 1'b0;
  logic                          in_ready;
  logic [SAMPLE_WIDTH-1:0]       in_sample    = '0;
  logic [TIME_WIDTH-1:0]         in_timestamp = '0;
  logic                          in_restart   = 1'b0;
  logic                          out_valid;
  logic                          out_ready    = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] out_filtered;
  logic                          out_initialized;
  logic                          out_time_stalled;

  // shadow of the config registers
  logic                  cfg_hp = 1'b0;
  logic                  cfg_ts = 1'b0;
  logic [RC_WIDTH-1:0]   cfg_rc = folhpf_pkg::RC_TICKS_RESET;
  logic [TIME_WIDTH-1:0] cfg_dt = folhpf_pkg::FIXED_DT_RESET;

  // filter state
  logic                  primed    = 1'b0;
  longint                last_out  = 0;
  longint                last_in   = 0;
  logic [TIME_WIDTH-1:0] last_time = '0;
  logic [TIME_WIDTH-1:0] last_dt   = '0;

  filt_result_t          expected_q[$];
  int                    errors       = 0;
  int                    in_idle_pct  = 13;
  int                    out_idle_pct = 13;
  int                    hold_request = 0;
  int                    hold_left    = 0;
  logic [TIME_WIDTH-1:0] ts_now       = '0;

  first_order_low_high_pass_filter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_timestamp     (in_timestamp),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_filtered     (out_filtered),
    .out_initialized  (out_initialized),
    .out_time_stalled (out_time_stalled)
  );

  always #1 clk = ~clk;

  function automatic longint smoothing_alpha(logic [TIME_WIDTH-1:0] dt);
    longint unsigned num;
    longint unsigned den;
    num = cfg_rc;
    den = cfg_rc;
    den = den + dt;
    if (den == 0) return 0;
    return longint'((num << ALPHA_FRAC_BITS) / den);
  endfunction

  function automatic filt_result_t predict_filter(logic signed [SAMPLE_WIDTH-1:0] sample,
                                                  logic [TIME_WIDTH-1:0] ts,
                                                  logic restart);
    filt_result_t r;
    longint       x;
    longint       a;
    longint       acc;
    longint       y;
    x = sample;
    r.initialized  = 1'b0;
    r.time_stalled = 1'b0;
    if (!primed || restart) begin
      primed        = 1'b1;
      r.initialized = 1'b1;
      y             = x;
      last_time     = cfg_ts ? ts : '0;
    end else begin
      if (cfg_ts) begin
        if (ts > last_time) begin
          last_dt = ts - last_time;
        end else begin
          r.time_stalled = 1'b1;
          primed         = 1'b0;
        end
        last_time = ts;
      end else begin
        last_dt = cfg_dt;
      end
      a = smoothing_alpha(last_dt);
      if (cfg_hp) acc = a * (last_out + x - last_in);
      else acc = a * last_out + (ALPHA_UNITY - a) * x;
      y = (acc + (ALPHA_UNITY >>> 1)) >>> ALPHA_FRAC_BITS;
      if (y > SAT_HI) y = SAT_HI;
      else if (y < SAT_LO) y = SAT_LO;
    end
    last_out   = y;
    last_in    = x;
    r.filtered = y[SAMPLE_WIDTH-1:0];
    return r;
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return $urandom_range(0, 1310720) - 655360;
    endcase
  endfunction

  function automatic logic [31:0] pick_ticks();
    case ($urandom_range(5))
      0: return '0;
      1: return 1;
      2: return TICKS_MAX;
      3: return $urandom;
      default: return $urandom_range(1, 5000);
    endcase
  endfunction

  // mostly advancing time, with some repeats, steps back and jumps
  function automatic logic [TIME_WIDTH-1:0] next_timestamp(logic [TIME_WIDTH-1:0] now,
                                                           int unsigned span);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 4) return now;
    if (roll < 7) return now - $urandom_range(0, span);
    if (roll < 9) return $urandom;
    return now + $urandom_range(1, span);
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] sample,
                             input logic [TIME_WIDTH-1:0] ts, input logic restart);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid     <= 1'b1;
    in_sample    <= sample;
    in_timestamp <= ts;
    in_restart   <= restart;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(predict_filter(sample, ts, restart));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // one-bit registers get random upper bits, which the block must ignore
  task automatic set_config(input logic hp, input logic ts, input logic [31:0] rc,
                            input logic [31:0] dt);
    logic [CFG_DATA_W-1:0] hp_word;
    logic [CFG_DATA_W-1:0] ts_word;
    hp_word    = $urandom;
    hp_word[0] = hp;
    ts_word    = $urandom;
    ts_word[0] = ts;
    write_reg(folhpf_pkg::REG_HIGH_PASS, hp_word);
    write_reg(folhpf_pkg::REG_USE_TIMESTAMPS, ts_word);
    write_reg(folhpf_pkg::REG_RC_TICKS, rc);
    write_reg(folhpf_pkg::REG_FIXED_DT_TICKS, dt);
    cfg_wr_en <= 1'b0;
    cfg_hp = hp;
    cfg_ts = ts;
    cfg_rc = rc;
    cfg_dt = dt;
  endtask

  task automatic test_reset_defaults();
    send_sample(SAMPLE_MAX, 32'd7, 1'b0);
    send_sample(SAMPLE_MIN, 32'd0, 1'b0);
    send_sample('0, TICKS_MAX, 1'b0);
    send_sample('1, 32'd3, 1'b0);
    send_sample(SAMPLE_MAX, TICKS_MAX, 1'b1);
    send_sample(32'd1, 32'd0, 1'b0);
  endtask

  task automatic test_zero_alpha();
    // zero denominator
    wait_idle();
    set_config(1'b0, 1'b0, '0, '0);
    send_sample(Q_ONE, '0, 1'b1);
    send_sample(-Q_ONE * 3, '0, 1'b0);
    // zero time constant in high-pass gives zero
    wait_idle();
    set_config(1'b1, 1'b0, '0, 32'd5);
    send_sample(SAMPLE_MIN, '0, 1'b1);
    send_sample(SAMPLE_MAX, '0, 1'b0);
    // zero dt holds the low-pass output
    wait_idle();
    set_config(1'b0, 1'b0, TICKS_MAX, '0);
    send_sample(Q_ONE * 5, '0, 1'b1);
    send_sample(SAMPLE_MIN, '0, 1'b0);
  endtask

  task automatic test_high_pass_saturation();
    wait_idle();
    set_config(1'b1, 1'b0, TICKS_MAX, 32'd1);
    send_sample(SAMPLE_MIN, '0, 1'b1);
    send_sample(SAMPLE_MAX, '0, 1'b0);
    send_sample(SAMPLE_MIN, '0, 1'b0);
    send_sample(SAMPLE_MAX, '0, 1'b0);
    send_sample(SAMPLE_MIN, '0, 1'b0);
  endtask

  task automatic test_timestamp_stall();
    wait_idle();
    set_config(1'b0, 1'b1, 32'd100, TICKS_MAX);
    send_sample(Q_ONE, 32'd10, 1'b1);
    send_sample(Q_ONE * 2, 32'd20, 1'b0);
    send_sample(Q_ONE * 4, 32'd20, 1'b0);
    send_sample(Q_ONE, 32'd30, 1'b0);
    send_sample(-Q_ONE, 32'd5, 1'b0);
    send_sample(Q_ONE * 7, TICKS_MAX, 1'b0);
    send_sample(Q_ONE, '0, 1'b0);
    send_sample(Q_ONE * 3, 32'd1, 1'b0);
  endtask

  task automatic test_random_sweep();
    int unsigned span;
    logic        restart;
    for (int p = 0; p < 10; p++) begin
      wait_idle();
      if (p == 0) set_config(1'b1, 1'b1, TICKS_MAX, '0);
      else if (p == 1) set_config(1'b0, 1'b0, 32'd1, TICKS_MAX);
      else set_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                      pick_ticks(), pick_ticks());
      span = 1 << $urandom_range(1, 24);
      for (int i = 0; i < 150; i++) begin
        restart = ($urandom_range(99) < 3);
        ts_now  = next_timestamp(ts_now, span);
        send_sample(pick_sample(), ts_now, restart);
      end
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    set_config(1'b0, 1'b1, 32'd1592, 32'd1000);
    // receiver holds off while the sender keeps offering
    hold_request = 300;
    for (int i = 0; i < 20; i++) begin
      ts_now = next_timestamp(ts_now, 2000);
      send_sample(pick_sample(), ts_now, 1'b0);
    end
    // sender pauses until everything has drained
    wait_idle();
    for (int i = 0; i < 20; i++) begin
      ts_now = next_timestamp(ts_now, 2000);
      send_sample(pick_sample(), ts_now, 1'b0);
    end
    // stretch with no idling on either side
    in_idle_pct  = 0;
    out_idle_pct = 0;
    for (int i = 0; i < 100; i++) begin
      ts_now = next_timestamp(ts_now, 2000);
      send_sample(pick_sample(), ts_now, $urandom_range(99) < 3);
    end
    in_idle_pct  = 13;
    out_idle_pct = 13;
  endtask

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    filt_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transaction, filtered %0d", $time, out_filtered);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_filtered !== exp_r.filtered) begin
          $display("%0t: filtered mismatch, expected %0d actual %0d",
                   $time, exp_r.filtered, out_filtered);
          errors++;
        end
        if (out_initialized !== exp_r.initialized) begin
          $display("%0t: initialized mismatch, expected %0b actual %0b",
                   $time, exp_r.initialized, out_initialized);
          errors++;
        end
        if (out_time_stalled !== exp_r.time_stalled) begin
          $display("%0t: time_stalled mismatch, expected %0b actual %0b",
                   $time, exp_r.time_stalled, out_time_stalled);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_zero_alpha();
    test_high_pass_saturation();
    test_timestamp_stall();
    test_random_sweep();
    test_backpressure();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("first_order_low_high_pass_filter test passed");
    end else begin
      $display("first_order_low_high_pass_filter test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("first_order_low_high_pass_filter test failed");
    $finish;
  end

endmodule
